[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SCB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// When a holds, c holds in the same cycle.
`define SCB_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("implication failed");

// When a holds, c holds in the following cycle.
`define SCB_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("next-cycle implication failed");

`endif

[hw/rtl/scb_pkg.sv]
`default_nettype none
package scb_pkg;

  localparam int PIXEL_COUNT_BITS = 22;
  localparam int CNT_W = PIXEL_COUNT_BITS + 1;
  localparam int THR_W = CNT_W + 17;
  localparam int FRAC_W = 15;
  localparam int NUM_CH = 3;
  localparam logic [CNT_W-1:0] PIX_LIMIT = {1'b1, {PIXEL_COUNT_BITS{1'b0}}};
  localparam logic [FRAC_W-1:0] FRAC_RESET = 15'd655;
  localparam logic [7:0] BIN_LAST = 8'hFF;
  localparam logic [7:0] HI_RAISE_LIMIT = 8'd254;
  localparam logic [1:0] ADDR_FRAC = 2'd0;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_CNT   = 8'b0000_0100,
    ST_SETUP = 8'b0000_1000,
    ST_WALK  = 8'b0001_0000,
    ST_DRAIN = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  typedef enum logic {
    CMD_COUNT   = 1'b0,
    CMD_STRETCH = 1'b1
  } command_e;

  typedef struct packed {
    logic       init;
    logic       valid;
    logic       last;
    logic [7:0] bin;
  } walk_ctl_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [2:0] idx;
  } div_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/scb_hist_mem.sv]
`default_nettype none
module scb_hist_mem (
  input  wire logic                     clk_i,
  input  wire logic [7:0]               addr_i,
  input  wire logic                     re_i,
  input  wire logic                     we_i,
  input  wire logic [scb_pkg::CNT_W-1:0] wdata_i,
  output logic      [scb_pkg::CNT_W-1:0] rdata_o
);

  logic [scb_pkg::CNT_W-1:0] mem [256];
  logic [scb_pkg::CNT_W-1:0] rdata_q;

  // Read returns the old contents when the same word is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/scb_bound_trk.sv]
`default_nettype none
module scb_bound_trk (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire scb_pkg::walk_ctl_t        ctl_i,
  input  wire logic [scb_pkg::CNT_W-1:0] rdata_i,
  input  wire logic [scb_pkg::THR_W-1:0] lo_thr_i,
  input  wire logic [scb_pkg::THR_W-1:0] hi_thr_i,
  output logic      [7:0]                lo_o,
  output logic      [7:0]                hi_o
);

  logic [scb_pkg::CNT_W-1:0] cum_q, cum_d;
  logic [7:0]                lo_w_q, lo_n, hi_w_q, hi_n;
  logic                      found_q, found_n;
  logic [scb_pkg::THR_W-1:0] cum_scaled;
  logic [7:0]                lo_q, hi_q;

  always_comb begin
    cum_d      = cum_q + rdata_i;
    cum_scaled = {1'b0, cum_d, 16'b0};
    lo_n       = lo_w_q;
    found_n    = found_q;
    hi_n       = hi_w_q;
    if (!found_q && (cum_scaled >= lo_thr_i)) begin
      lo_n    = ctl_i.bin;
      found_n = 1'b1;
    end
    if (cum_scaled <= hi_thr_i) begin
      hi_n = ctl_i.bin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cum_q   <= '0;
      lo_w_q  <= scb_pkg::BIN_LAST;
      found_q <= 1'b0;
      hi_w_q  <= '0;
      lo_q    <= '0;
      hi_q    <= scb_pkg::BIN_LAST;
    end else if (ctl_i.init) begin
      cum_q   <= '0;
      lo_w_q  <= scb_pkg::BIN_LAST;
      found_q <= 1'b0;
      hi_w_q  <= '0;
    end else if (ctl_i.valid) begin
      cum_q   <= cum_d;
      lo_w_q  <= lo_n;
      found_q <= found_n;
      hi_w_q  <= hi_n;
      if (ctl_i.last) begin
        lo_q <= lo_n;
        hi_q <= (hi_n < scb_pkg::HI_RAISE_LIMIT) ? hi_n + 8'd1 : hi_n;
      end
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule
`default_nettype wire

[hw/rtl/scb_div.sv]
`default_nettype none
module scb_div (
  input  wire logic              clk_i,
  input  wire scb_pkg::div_ctl_t ctl_i,
  input  wire logic [7:0]        v_i,
  input  wire logic [7:0]        lo_i,
  input  wire logic [7:0]        hi_i,
  output logic      [7:0]        q_o
);

  logic [7:0]  vc, x, den_q;
  logic [15:0] rem_q, dsh;
  logic [7:0]  q_q;
  logic        empty_q;

  always_comb begin
    vc = v_i;
    if (v_i < lo_i) begin
      vc = lo_i;
    end
    if (v_i > hi_i) begin
      vc = hi_i;
    end
    x   = vc - lo_i;
    dsh = {8'b0, den_q} << ctl_i.idx;
  end

  // Restoring division, one quotient bit a cycle from the top; the quotient
  // is known to stay below 256 because the clamped span never exceeds the divisor.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rem_q   <= {x, 8'b0} - {8'b0, x};
      den_q   <= hi_i - lo_i;
      empty_q <= (hi_i <= lo_i);
      q_q     <= '0;
    end else if (ctl_i.step) begin
      if (rem_q >= dsh) begin
        rem_q          <= rem_q - dsh;
        q_q[ctl_i.idx] <= 1'b1;
      end
    end
  end

  assign q_o = empty_q ? 8'd0 : q_q;

endmodule
`default_nettype wire

[hw/rtl/simplest_color_balance.sv]
// Channel          Direction  Handshake               Content
// pixel command    in         start high, busy low    command, sample_c0..c2, end_of_frame
// stretched pixel  out        result_valid_o strobe   stretched_c0..c2, frame_end
// configuration    in/out     APB write access phase  discard_fraction at byte address 0
//
// A count item reads the bin from the histogram memory and writes it back
// incremented. A count item that ends the frame is followed by a bound walk,
// one bin a cycle over the three memories at once.
// A stretch item runs through the eight-step shared-free divider per channel;
// a new item is taken in the cycle its result is shown.
// After reset the memories are swept to zero while busy is high.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none
`include "assert_macros.svh"
module simplest_color_balance (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       command_i,
  input  wire logic [7:0] sample_c0_i,
  input  wire logic [7:0] sample_c1_i,
  input  wire logic [7:0] sample_c2_i,
  input  wire logic       end_of_frame_i,
  output logic            result_valid_o,
  output logic      [7:0] stretched_c0_o,
  output logic      [7:0] stretched_c1_o,
  output logic      [7:0] stretched_c2_o,
  output logic            frame_end_o,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic            pready
);

  scb_pkg::state_e st_q, st_d;

  logic [scb_pkg::FRAC_W-1:0] frac_q;
  logic [scb_pkg::CNT_W-1:0]  total_q;
  logic [scb_pkg::THR_W-1:0]  lo_thr_q, hi_thr_q;
  logic [7:0]                 walk_q;
  logic                       rv_q;
  logic [7:0]                 rbin_q;
  logic [2:0]                 idx_q;
  logic                       eof_q;
  logic [7:0]                 samp_q [scb_pkg::NUM_CH];
  logic [7:0]                 samp_in [scb_pkg::NUM_CH];
  logic [7:0]                 q_ch [scb_pkg::NUM_CH];
  logic [7:0]                 lo_ch [scb_pkg::NUM_CH];
  logic [7:0]                 hi_ch [scb_pkg::NUM_CH];
  logic [scb_pkg::CNT_W-1:0]  rdata_ch [scb_pkg::NUM_CH];
  logic [7:0]                 addr_ch [scb_pkg::NUM_CH];

  logic accept, accept_cnt, accept_str, room, mem_re, mem_we, walk_mid;
  scb_pkg::walk_ctl_t wctl;
  scb_pkg::div_ctl_t  dctl;

  assign samp_in[0] = sample_c0_i;
  assign samp_in[1] = sample_c1_i;
  assign samp_in[2] = sample_c2_i;

  // The block can take an item when idle or while the last result is shown.
  assign busy       = !((st_q == scb_pkg::ST_IDLE) || (st_q == scb_pkg::ST_EMIT));
  assign accept     = start && !busy;
  assign accept_cnt = accept && (command_i == scb_pkg::CMD_COUNT);
  assign accept_str = accept && (command_i == scb_pkg::CMD_STRETCH);
  assign room       = total_q < scb_pkg::PIX_LIMIT;

  // Configuration port. Every write lands on the only register; reads of any
  // other word return zero.
  assign pready = 1'b1;
  assign prdata = (paddr == scb_pkg::ADDR_FRAC) ?
                  {{(32 - scb_pkg::FRAC_W){1'b0}}, frac_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= scb_pkg::FRAC_RESET;
    end else if (psel && penable && pwrite && pready) begin
      frac_q <= pwdata[scb_pkg::FRAC_W-1:0];
    end
  end

  // Memory control. The count path reads at acceptance and writes back in the
  // following cycle, so two accesses to one bin never overlap. The walk reads
  // each bin and zeroes it in the same cycle, which also clears the frame.
  assign mem_re = accept_cnt || (st_q == scb_pkg::ST_WALK);
  assign mem_we = ((st_q == scb_pkg::ST_CNT) && room) || (st_q == scb_pkg::ST_WALK) ||
                  (st_q == scb_pkg::ST_CLEAR);

  always_comb begin
    for (int c = 0; c < scb_pkg::NUM_CH; c++) begin
      case (st_q)
        scb_pkg::ST_CNT:   addr_ch[c] = samp_q[c];
        scb_pkg::ST_WALK,
        scb_pkg::ST_CLEAR: addr_ch[c] = walk_q;
        default:           addr_ch[c] = samp_in[c];
      endcase
    end
  end

  assign wctl.init  = (st_q == scb_pkg::ST_SETUP);
  assign wctl.valid = rv_q;
  assign wctl.last  = rv_q && (rbin_q == scb_pkg::BIN_LAST);
  assign wctl.bin   = rbin_q;

  assign dctl.load = accept_str;
  assign dctl.step = (st_q == scb_pkg::ST_DIV);
  assign dctl.idx  = idx_q;

  for (genvar c = 0; c < scb_pkg::NUM_CH; c++) begin : g_ch
    logic [scb_pkg::CNT_W-1:0] wdata;
    assign wdata = (st_q == scb_pkg::ST_CNT) ? rdata_ch[c] + 1'b1 : '0;

    scb_hist_mem u_mem (
      .clk_i   (clk_i),
      .addr_i  (addr_ch[c]),
      .re_i    (mem_re),
      .we_i    (mem_we),
      .wdata_i (wdata),
      .rdata_o (rdata_ch[c])
    );

    scb_bound_trk u_trk (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (wctl),
      .rdata_i  (rdata_ch[c]),
      .lo_thr_i (lo_thr_q),
      .hi_thr_i (hi_thr_q),
      .lo_o     (lo_ch[c]),
      .hi_o     (hi_ch[c])
    );

    scb_div u_div (
      .clk_i (clk_i),
      .ctl_i (dctl),
      .v_i   (samp_in[c]),
      .lo_i  (lo_ch[c]),
      .hi_i  (hi_ch[c]),
      .q_o   (q_ch[c])
    );
  end

  // Sequencer.
  always_comb begin
    st_d = st_q;
    case (st_q)
      scb_pkg::ST_CLEAR: if (walk_q == scb_pkg::BIN_LAST) st_d = scb_pkg::ST_IDLE;
      scb_pkg::ST_IDLE,
      scb_pkg::ST_EMIT: begin
        if (accept_cnt) begin
          st_d = scb_pkg::ST_CNT;
        end else if (accept_str) begin
          st_d = scb_pkg::ST_DIV;
        end else begin
          st_d = scb_pkg::ST_IDLE;
        end
      end
      scb_pkg::ST_CNT:   st_d = eof_q ? scb_pkg::ST_SETUP : scb_pkg::ST_IDLE;
      scb_pkg::ST_SETUP: st_d = scb_pkg::ST_WALK;
      scb_pkg::ST_WALK:  if (walk_q == scb_pkg::BIN_LAST) st_d = scb_pkg::ST_DRAIN;
      scb_pkg::ST_DRAIN: st_d = scb_pkg::ST_IDLE;
      scb_pkg::ST_DIV:   if (idx_q == 3'd0) st_d = scb_pkg::ST_EMIT;
      default:           st_d = scb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= scb_pkg::ST_CLEAR;
      walk_q  <= '0;
      total_q <= '0;
      rv_q    <= 1'b0;
      rbin_q  <= '0;
      idx_q   <= '0;
    end else begin
      st_q   <= st_d;
      rv_q   <= (st_q == scb_pkg::ST_WALK);
      rbin_q <= walk_q;
      if ((st_q == scb_pkg::ST_WALK) || (st_q == scb_pkg::ST_CLEAR)) begin
        walk_q <= walk_q + 8'd1;
      end else begin
        walk_q <= '0;
      end
      if ((st_q == scb_pkg::ST_CNT) && room) begin
        total_q <= total_q + 1'b1;
      end else if (st_q == scb_pkg::ST_DRAIN) begin
        total_q <= '0;
      end
      if (accept_str) begin
        idx_q <= 3'd7;
      end else if (st_q == scb_pkg::ST_DIV) begin
        idx_q <= idx_q - 3'd1;
      end
    end
  end

  // Item payload and thresholds; these need no reset. The products are formed
  // at the full threshold width so that no bit of them is lost.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      eof_q <= end_of_frame_i;
      for (int c = 0; c < scb_pkg::NUM_CH; c++) begin
        samp_q[c] <= samp_in[c];
      end
    end
    if (st_q == scb_pkg::ST_SETUP) begin
      lo_thr_q <= scb_pkg::THR_W'(frac_q) * scb_pkg::THR_W'(total_q);
      hi_thr_q <= scb_pkg::THR_W'(17'h10000 - {2'b0, frac_q}) * scb_pkg::THR_W'(total_q);
    end
  end

  assign result_valid_o = (st_q == scb_pkg::ST_EMIT);
  assign stretched_c0_o = q_ch[0];
  assign stretched_c1_o = q_ch[1];
  assign stretched_c2_o = q_ch[2];
  assign frame_end_o    = eof_q;

  assign walk_mid = (st_q == scb_pkg::ST_WALK) && (walk_q != scb_pkg::BIN_LAST);

  `SCB_ASSERT_IMPL(a_strobe_after_div, result_valid_o, $past(st_q == scb_pkg::ST_DIV))
  `SCB_ASSERT(a_total_in_range, total_q <= scb_pkg::PIX_LIMIT)
  `SCB_ASSERT_NEXT(a_walk_continues, walk_mid, st_q == scb_pkg::ST_WALK)

endmodule
`default_nettype wire
